// ===== rtl/psat_pkg.sv =====
// ----------------------------------------------------------------------------
// psat_pkg
// Shared types, command codes and tables for the point set transform core.
// ----------------------------------------------------------------------------
package psat_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int CORDIC_STEPS   = 20;

    // command codes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_MOVE  = 3'd1;
    localparam logic [2:0] OP_ROT_X = 3'd2;
    localparam logic [2:0] OP_ROT_Y = 3'd3;
    localparam logic [2:0] OP_ROT_Z = 3'd4;
    localparam logic [2:0] OP_SCALE = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0]        angle;
        logic signed [23:0] factor;
    } t_cmd;

    typedef struct packed {
        logic [5:0]         point_index;
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic               last;
        logic               empty_res;
        logic               dropped;
    } t_res;

    // arctangent table in turns, Q0.32 scaled
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        begin
            case (i)
                5'd0:  v = 30'h20000000;
                5'd1:  v = 30'h12E4051E;
                5'd2:  v = 30'h09FB385B;
                5'd3:  v = 30'h051111D4;
                5'd4:  v = 30'h028B0D43;
                5'd5:  v = 30'h0145D7E1;
                5'd6:  v = 30'h00A2F61E;
                5'd7:  v = 30'h00517C55;
                5'd8:  v = 30'h0028BE53;
                5'd9:  v = 30'h00145F2F;
                5'd10: v = 30'h000A2F98;
                5'd11: v = 30'h000517CC;
                5'd12: v = 30'h00028BE6;
                5'd13: v = 30'h000145F3;
                5'd14: v = 30'h0000A2FA;
                5'd15: v = 30'h0000517D;
                5'd16: v = 30'h000028BE;
                5'd17: v = 30'h0000145F;
                5'd18: v = 30'h00000A30;
                5'd19: v = 30'h00000518;
                default: v = 30'h0;
            endcase
            return v;
        end
    endfunction

    // saturate a 34-bit signed value to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        begin
            if (v > 34'sh07FFFFFFF) r = 32'sh7FFFFFFF;
            else if (v < -34'sh080000000) r = 32'sh80000000;
            else r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ===== rtl/psat_if.sv =====
// ----------------------------------------------------------------------------
// psat_cmd_if / psat_res_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface psat_cmd_if;
    logic            valid;
    logic            ready;
    psat_pkg::t_cmd  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psat_res_if;
    logic            valid;
    logic            ready;
    psat_pkg::t_res  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/point_set_affine_transform_core.sv =====
// ----------------------------------------------------------------------------
// point_set_affine_transform_core
// Point store with add, move, rotate, scale and read commands.
//
// Usage: requests arrive on the cmd channel (valid/ready); each is taken
// only while the block is idle, and ready stays low while it works.
// Read results leave on the res channel, one per stored point, the last
// marked; an empty store gives one result flagged empty.
// Add and move finish on acceptance; rotate computes sine/cosine first,
// then reads, multiplies and writes back each point; scale does the
// same per point without sine/cosine; read walks the points, paused by
// receiver stalls. The shared multiplier handles one product per cycle.
// Reset (synchronous, active low) empties the store, clears the offset and
// the dropped flag. Store entries are not cleared; only the count matters.
// A stalled receiver holds the result register and pauses the read walk.
// ----------------------------------------------------------------------------
module point_set_affine_transform_core #(
    parameter int MAX_POINTS = psat_pkg::MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psat_cmd_if.sink    i_cmd,
    psat_res_if.source  o_res
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    // states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CS   = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_MUL  = 4'd3;
    localparam logic [3:0] S_WB   = 4'd4;
    localparam logic [3:0] S_OUT  = 4'd5;
    localparam logic [3:0] S_RDW  = 4'd6;

    logic [3:0]         r_state;
    logic [2:0]         r_op;
    logic signed [23:0] r_factor;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_idx;
    logic [3:0]         r_ph;
    logic signed [31:0] r_off_x, r_off_y, r_off_z;
    logic               r_dropped;
    logic signed [31:0] r_px, r_py, r_pz;
    logic signed [31:0] r_n0;
    logic signed [17:0] r_sin, r_cos;

    logic               w_cs_start, w_cs_done;
    logic signed [17:0] w_sin, w_cos;
    logic               w_we;
    logic [AW-1:0]      w_waddr, w_raddr;
    logic signed [31:0] w_wx, w_wy, w_wz, w_rx, w_ry, w_rz;
    logic               w_mac_en, w_mac_clr, w_mac_acc;
    logic signed [31:0] w_a, w_mres;
    logic signed [24:0] w_b;
    logic               w_acc_cmd, w_last_pt;
    logic [AW-1:0]      w_add_addr;
    logic               w_out_fire;

    assign w_acc_cmd  = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_last_pt  = (CW'(r_idx) + CW'(1) == r_count);
    assign w_add_addr = r_count[AW-1:0];
    assign w_out_fire = (r_state == S_OUT) && (!o_res.valid || o_res.ready);

    psat_cordic u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_cs_start),
        .i_angle(i_cmd.data.angle), .o_done(w_cs_done), .o_sin(w_sin), .o_cos(w_cos)
    );

    psat_mac u_mac (
        .i_clk(i_clk), .i_en(w_mac_en), .i_clr(w_mac_clr), .i_a(w_a), .i_b(w_b),
        .i_acc(w_mac_acc), .o_res(w_mres)
    );

    psat_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wx),
        .i_raddr(w_raddr), .o_rdata(w_rx));
    psat_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wy),
        .i_raddr(w_raddr), .o_rdata(w_ry));
    psat_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_z (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wz),
        .i_raddr(w_raddr), .o_rdata(w_rz));

    assign w_raddr    = r_idx;
    assign w_cs_start = (r_state == S_IDLE) && w_acc_cmd &&
                        (i_cmd.data.op == psat_pkg::OP_ROT_X ||
                         i_cmd.data.op == psat_pkg::OP_ROT_Y ||
                         i_cmd.data.op == psat_pkg::OP_ROT_Z);

    // store write port: append on add, write back after a transform
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wx    = r_px;
        w_wy    = r_py;
        w_wz    = r_pz;
        if (r_state == S_IDLE) begin
            w_waddr = w_add_addr;
            w_wx    = i_cmd.data.coord_x;
            w_wy    = i_cmd.data.coord_y;
            w_wz    = i_cmd.data.coord_z;
            w_we    = w_acc_cmd && i_cmd.data.op == psat_pkg::OP_ADD &&
                      r_count < CW'(MAX_POINTS);
        end else if (r_state == S_WB) begin
            w_we = 1'b1;
        end
    end

    // multiplier operand schedule per phase
    // rotate: phases 0,1 feed product pair A, 3,4 feed pair B; scale: two per axis
    always_comb begin
        w_a       = r_px;
        w_b       = 25'(r_cos);
        w_mac_en  = (r_state == S_MUL);
        w_mac_clr = 1'b0;
        w_mac_acc = 1'b0;
        if (r_state == S_MUL) begin
            if (r_op == psat_pkg::OP_SCALE) begin
                w_b = 25'(r_factor);
                case (r_ph) inside
                    4'd0, 4'd1: w_a = r_px;
                    4'd2, 4'd3: w_a = r_py;
                    default:    w_a = r_pz;
                endcase
                // clear, then add the one product; results are taken at phases 2, 4 and 6
                w_mac_clr = (r_ph == 4'd0) || (r_ph == 4'd2) || (r_ph == 4'd4);
                w_mac_acc = (r_ph == 4'd1) || (r_ph == 4'd3) || (r_ph == 4'd5);
            end else begin
                // sources u,v per axis: X (y,z) Y (x,z) Z (x,y)
                case (r_ph) inside
                    4'd0: begin w_a = (r_op == psat_pkg::OP_ROT_X) ? r_py : r_px;
                          w_b = 25'(r_cos); end
                    4'd1: begin w_a = (r_op == psat_pkg::OP_ROT_Z) ? r_py : r_pz;
                          w_b = (r_op == psat_pkg::OP_ROT_Z) ? -25'(r_sin) : 25'(r_sin);
                          end
                    4'd2, 4'd3: begin w_a = (r_op == psat_pkg::OP_ROT_X) ? r_py : r_px;
                          w_b = (r_op == psat_pkg::OP_ROT_Z) ? 25'(r_sin) : -25'(r_sin);
                          end
                    default: begin w_a = (r_op == psat_pkg::OP_ROT_Z) ? r_py : r_pz;
                          w_b = 25'(r_cos); end
                endcase
                w_mac_clr = (r_ph == 4'd0) || (r_ph == 4'd3);
                w_mac_acc = (r_ph == 4'd1) || (r_ph == 4'd2) ||
                            (r_ph == 4'd4) || (r_ph == 4'd5);
            end
        end
    end

    // result valid: set on a new result, cleared once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_res.valid <= 1'b0;
        end else if (w_out_fire) begin
            o_res.valid <= 1'b1;
        end else if (o_res.valid && o_res.ready) begin
            o_res.valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_off_x   <= '0;
            r_off_y   <= '0;
            r_off_z   <= '0;
            r_dropped <= 1'b0;
            r_idx     <= '0;
            r_ph      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_ph  <= '0;
                    if (w_acc_cmd) begin
                        r_op     <= i_cmd.data.op;
                        r_factor <= i_cmd.data.factor;
                        case (i_cmd.data.op) inside
                            psat_pkg::OP_ADD: begin
                                if (r_count < CW'(MAX_POINTS)) r_count <= r_count + CW'(1);
                                else r_dropped <= 1'b1;
                            end
                            psat_pkg::OP_MOVE: begin
                                r_off_x <= psat_pkg::sat34(34'(r_off_x) + 34'(i_cmd.data.coord_x));
                                r_off_y <= psat_pkg::sat34(34'(r_off_y) + 34'(i_cmd.data.coord_y));
                                r_off_z <= psat_pkg::sat34(34'(r_off_z) + 34'(i_cmd.data.coord_z));
                            end
                            psat_pkg::OP_ROT_X, psat_pkg::OP_ROT_Y,
                            psat_pkg::OP_ROT_Z: r_state <= S_CS;
                            psat_pkg::OP_SCALE: if (r_count != '0) r_state <= S_RD;
                            psat_pkg::OP_READ:  r_state <= (r_count != '0) ? S_RD : S_OUT;
                            default: ;
                        endcase
                    end
                end
                S_CS: if (w_cs_done) begin
                    r_sin   <= w_sin;
                    r_cos   <= w_cos;
                    r_state <= (r_count != '0) ? S_RD : S_IDLE;
                end
                S_RD: r_state <= S_RDW;
                S_RDW: begin
                    r_px <= w_rx;
                    r_py <= w_ry;
                    r_pz <= w_rz;
                    r_ph <= '0;
                    r_state <= (r_op == psat_pkg::OP_READ) ? S_OUT : S_MUL;
                end
                S_MUL: begin
                    r_ph <= r_ph + 4'd1;
                    if (r_op == psat_pkg::OP_SCALE) begin
                        if (r_ph == 4'd2) r_n0 <= w_mres;
                        if (r_ph == 4'd4) r_py <= w_mres;
                        if (r_ph == 4'd6) begin
                            r_px <= r_n0;
                            r_pz <= w_mres;
                            r_state <= S_WB;
                        end
                    end else begin
                        if (r_ph == 4'd3) r_n0 <= w_mres;
                        if (r_ph == 4'd6) begin
                            unique case (r_op)
                                psat_pkg::OP_ROT_X: begin r_py <= r_n0; r_pz <= w_mres; end
                                psat_pkg::OP_ROT_Y: begin r_px <= r_n0; r_pz <= w_mres; end
                                default:            begin r_px <= r_n0; r_py <= w_mres; end
                            endcase
                            r_state <= S_WB;
                        end
                    end
                end
                S_WB: begin
                    if (w_last_pt) r_state <= S_IDLE;
                    else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_RD;
                    end
                end
                S_OUT: if (w_out_fire) begin
                    o_res.data.dropped <= r_dropped;
                    if (r_count == '0) begin
                        o_res.data.point_index <= '0;
                        o_res.data.out_x <= r_off_x;
                        o_res.data.out_y <= r_off_y;
                        o_res.data.out_z <= r_off_z;
                        o_res.data.last <= 1'b1;
                        o_res.data.empty_res <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        o_res.data.point_index <= 6'(r_idx);
                        o_res.data.out_x <= psat_pkg::sat34(34'(r_px) + 34'(r_off_x));
                        o_res.data.out_y <= psat_pkg::sat34(34'(r_py) + 34'(r_off_y));
                        o_res.data.out_z <= psat_pkg::sat34(34'(r_pz) + 34'(r_off_z));
                        o_res.data.last <= w_last_pt;
                        o_res.data.empty_res <= 1'b0;
                        if (w_last_pt) r_state <= S_IDLE;
                        else begin
                            r_idx   <= r_idx + AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/psat_ram.sv =====
// ----------------------------------------------------------------------------
// psat_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/psat_cordic.sv =====
// ----------------------------------------------------------------------------
// psat_cordic
// Iterative sine/cosine: one CORDIC micro-rotation per cycle, 20 steps.
// ----------------------------------------------------------------------------
module psat_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [15:0]         i_angle,
    output logic                o_done,
    output logic signed [17:0]  o_sin,
    output logic signed [17:0]  o_cos
);
    logic               r_busy;
    logic [4:0]         r_step;
    logic               r_neg;
    logic signed [33:0] r_x, r_y, r_z;
    logic signed [33:0] w_dx, w_dy, w_at;
    logic [31:0]        w_t;
    logic signed [33:0] w_fx, w_fy;
    logic signed [33:0] w_rx, w_ry;

    // fold angle into the right half-plane
    assign w_t = (i_angle[15] ^ i_angle[14]) ? {i_angle, 16'h0} - 32'h80000000
                                             : {i_angle, 16'h0};
    assign w_dx = r_y >>> r_step;
    assign w_dy = r_x >>> r_step;
    assign w_at = {4'h0, psat_pkg::atan_turn(r_step)};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 5'(psat_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
                r_step <= r_step + 5'd1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_angle[15] ^ i_angle[14];
            r_x   <= psat_pkg::CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= {{2{w_t[31]}}, w_t};
        end else if (r_busy) begin
            if (!r_z[33]) begin
                r_x <= r_x - w_dx; r_y <= r_y + w_dy; r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_dx; r_y <= r_y - w_dy; r_z <= r_z + w_at;
            end
        end
    end

    // round to Q1.16 and clamp
    assign w_fx = r_neg ? -r_x : r_x;
    assign w_fy = r_neg ? -r_y : r_y;
    assign w_rx = (w_fx + 34'sd8192) >>> 14;
    assign w_ry = (w_fy + 34'sd8192) >>> 14;
    assign o_cos = (w_rx > 34'sd65536) ? 18'sd65536 :
                   (w_rx < -34'sd65536) ? -18'sd65536 : w_rx[17:0];
    assign o_sin = (w_ry > 34'sd65536) ? 18'sd65536 :
                   (w_ry < -34'sd65536) ? -18'sd65536 : w_ry[17:0];
endmodule

// ===== rtl/psat_mac.sv =====
// ----------------------------------------------------------------------------
// psat_mac
// Shared 32x25 multiplier with registered product and accumulator;
// rounds half up at bit 16 and saturates to 32 bits.
// ----------------------------------------------------------------------------
module psat_mac (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_clr,
    input  logic signed [31:0] i_a,
    input  logic signed [24:0] i_b,
    input  logic               i_acc,
    output logic signed [31:0] o_res
);
    logic signed [56:0] r_prod;
    logic signed [57:0] r_acc;
    logic signed [57:0] w_sh;

    // product stage, then accumulate stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
        if (i_clr) begin
            r_acc <= 58'sd32768;
        end else if (i_acc) begin
            r_acc <= r_acc + 58'(r_prod);
        end
    end

    assign w_sh  = r_acc >>> 16;
    assign o_res = (w_sh > 58'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                   (w_sh < -58'sh80000000) ? 32'sh80000000 : w_sh[31:0];
endmodule
